FILE: rtl/core/jmce_pkg.sv
// ----------------------------------------------------------------------------
// jmce_pkg
// Shared constants, field widths and helpers for the joystick mode command
// encoder and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package jmce_pkg;

    localparam int ByteW  = 8;
    localparam int StickW = 9;
    localparam int AccelW = 10;
    localparam int LampW  = 4;
    localparam int ModeW  = 3;

    localparam int InDataW  = 6 * ByteW;
    localparam int OutDataW = 64;

    // Output tdata bit offsets, lowest field first
    localparam int StickXLo = 0;
    localparam int StickYLo = StickXLo + StickW;
    localparam int AccelXLo = StickYLo + StickW;
    localparam int AccelYLo = AccelXLo + AccelW;
    localparam int AccelZLo = AccelYLo + AccelW;
    localparam int BtnZLo   = AccelZLo + AccelW;
    localparam int BtnCLo   = BtnZLo + 1;
    localparam int CmdLo    = BtnCLo + 1;
    localparam int LampLo   = CmdLo + ByteW;
    localparam int PadW     = OutDataW - (LampLo + LampW);

    localparam logic [ByteW-1:0] KEY_BYTE = 8'h17;

    localparam logic [ByteW-1:0] CMD_AUTO  = 8'h0F;
    localparam logic [ByteW-1:0] CMD_MOVE  = 8'h80;
    localparam logic [ByteW-1:0] CMD_AIM   = 8'h40;
    localparam logic [ByteW-1:0] CMD_SHOOT = 8'h50;
    localparam logic [ByteW-1:0] CMD_NONE  = 8'h00;

    localparam logic [ByteW-1:0] DIR_UP    = 8'h08;
    localparam logic [ByteW-1:0] DIR_DOWN  = 8'h04;
    localparam logic [ByteW-1:0] DIR_LEFT  = 8'h02;
    localparam logic [ByteW-1:0] DIR_RIGHT = 8'h01;

    localparam logic [LampW-1:0] LAMP_NONE  = 4'h0;
    localparam logic [LampW-1:0] LAMP_AUTO  = 4'h8;
    localparam logic [LampW-1:0] LAMP_DRIVE = 4'h4;
    localparam logic [LampW-1:0] LAMP_AIM   = 4'h2;
    localparam logic [LampW-1:0] LAMP_SHOOT = 4'h1;

    typedef logic signed [StickW-1:0] stick_t;

    // Undo the controller byte scrambling
    function automatic logic [ByteW-1:0] decode_byte(input logic [ByteW-1:0] b);
        decode_byte = (b ^ KEY_BYTE) + KEY_BYTE;
    endfunction

    // OR the joystick direction bits onto a command base
    function automatic logic [ByteW-1:0] dir_cmd(input logic [ByteW-1:0] base,
                                                 input stick_t x,
                                                 input stick_t y);
        logic [ByteW-1:0] c;
        c = base;
        if (!y[StickW-1] && (y != '0)) c = c | DIR_UP;
        if (y[StickW-1])               c = c | DIR_DOWN;
        if (x[StickW-1])               c = c | DIR_LEFT;
        if (!x[StickW-1] && (x != '0)) c = c | DIR_RIGHT;
        dir_cmd = c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/joystick_mode_command_encoder.sv
// ----------------------------------------------------------------------------
// joystick_mode_command_encoder
// Decodes raw 6-byte controller reports and runs the drive / aim / auto mode
// machine that turns them into command bytes and lamp patterns.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  tdata                         tuser
//  s_axis    in         6 report bytes, 48 bits       -
//  m_axis    out        decoded report, 64 bits       command_valid
//
//  One report per cycle: decode, centre subtract, direction compare and the
//  mode step all sit between the accepted transaction and the result register.
//  The result is registered: m_tvalid rises in the cycle after the input transaction.
//  Reset (rst_n low) returns the mode to calibrate and clears the centre.
//  While a result waits on m_tready low the input stalls; with m_tready high
//  a new report is taken every cycle.
//
`default_nettype none

module joystick_mode_command_encoder
    import jmce_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // s_tdata, lowest bit up: report_byte0 .. report_byte5 (8 bits each)
    input  wire logic [InDataW-1:0]  s_tdata,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // m_tdata, lowest bit up: stick_x(9) stick_y(9) accel_x(10) accel_y(10)
    // accel_z(10) button_z_up(1) button_c_up(1) command_byte(8) lamps(4) pad(2)
    output      logic [OutDataW-1:0] m_tdata,
    // m_tuser: command_valid(1)
    output      logic                m_tuser
);

    // Mode codes
    localparam logic [ModeW-1:0] MODE_CAL       = 3'd0;
    localparam logic [ModeW-1:0] MODE_DRIVE     = 3'd1;
    localparam logic [ModeW-1:0] MODE_AIM       = 3'd2;
    localparam logic [ModeW-1:0] MODE_SHOOT     = 3'd3;
    localparam logic [ModeW-1:0] MODE_TO_AUTO   = 3'd4;
    localparam logic [ModeW-1:0] MODE_AUTO      = 3'd5;
    localparam logic [ModeW-1:0] MODE_AUTO_EXIT = 3'd6;

    logic [ModeW-1:0]    mode_reg, mode_next;
    logic [ByteW-1:0]    centre_x_reg, centre_x_next;
    logic [ByteW-1:0]    centre_y_reg, centre_y_next;
    logic                leave_aim_reg, leave_aim_next;

    logic                out_valid_reg;
    logic [OutDataW-1:0] out_data_reg, out_data_next;
    logic                out_user_reg, out_user_next;

    logic                accept;
    logic [ByteW-1:0]    d0, d1, d2, d3, d4, d5;
    logic                z_up, c_up;
    logic [AccelW-1:0]   ax, ay, az;
    stick_t              jx, jy;
    logic                cmd_valid;
    logic [ByteW-1:0]    cmd;
    logic [LampW-1:0]    lamps;

    // Take a new report whenever the result register is empty or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Byte decode and field unpack
    always_comb
    begin
        d0 = decode_byte(s_tdata[0*ByteW +: ByteW]);
        d1 = decode_byte(s_tdata[1*ByteW +: ByteW]);
        d2 = decode_byte(s_tdata[2*ByteW +: ByteW]);
        d3 = decode_byte(s_tdata[3*ByteW +: ByteW]);
        d4 = decode_byte(s_tdata[4*ByteW +: ByteW]);
        d5 = decode_byte(s_tdata[5*ByteW +: ByteW]);

        z_up = d5[0];
        c_up = d5[1];

        // 10-bit accelerometer: high byte then two low bits, bit order swapped
        ax = {d2, d5[2], d5[3]};
        ay = {d3, d5[4], d5[5]};
        az = {d4, d5[6], d5[7]};
    end

    // Centre capture happens on the calibration report itself
    always_comb
    begin
        centre_x_next = centre_x_reg;
        centre_y_next = centre_y_reg;
        if (mode_reg == MODE_CAL)
        begin
            centre_x_next = d0;
            centre_y_next = d1;
        end
        jx = stick_t'({1'b0, d0}) - stick_t'({1'b0, centre_x_next});
        jy = stick_t'({1'b0, d1}) - stick_t'({1'b0, centre_y_next});
    end

    // Mode machine
    always_comb
    begin
        mode_next      = mode_reg;
        leave_aim_next = leave_aim_reg;
        cmd_valid      = 1'b0;
        cmd            = CMD_NONE;
        lamps          = LAMP_NONE;

        unique case (mode_reg)
            MODE_CAL:
            begin
                mode_next = MODE_DRIVE;
            end
            MODE_AIM:
            begin
                if (!c_up)
                begin
                    // C pressed: arm the shot, remember whether Z was up
                    lamps          = LAMP_AIM | LAMP_SHOOT;
                    leave_aim_next = z_up;
                    mode_next      = MODE_SHOOT;
                end
                else
                begin
                    cmd_valid = 1'b1;
                    cmd       = dir_cmd(CMD_AIM, jx, jy);
                    if (z_up)
                    begin
                        lamps     = LAMP_DRIVE;
                        mode_next = MODE_DRIVE;
                    end
                    else
                    begin
                        lamps = LAMP_AIM;
                    end
                end
            end
            MODE_SHOOT:
            begin
                if (!c_up)
                begin
                    lamps = LAMP_AIM | LAMP_SHOOT;
                end
                else
                begin
                    // C released: fire
                    cmd_valid = 1'b1;
                    cmd       = CMD_SHOOT;
                    if (leave_aim_reg)
                    begin
                        lamps     = LAMP_DRIVE;
                        mode_next = MODE_DRIVE;
                    end
                    else
                    begin
                        lamps     = LAMP_AIM;
                        mode_next = MODE_AIM;
                    end
                end
            end
            MODE_TO_AUTO:
            begin
                lamps = LAMP_DRIVE;
                if (c_up)
                begin
                    cmd_valid = 1'b1;
                    cmd       = CMD_AUTO;
                    mode_next = MODE_AUTO;
                end
            end
            MODE_AUTO:
            begin
                // Z is ignored in auto
                cmd_valid = 1'b1;
                cmd       = CMD_AUTO;
                if (!c_up)
                begin
                    lamps     = LAMP_DRIVE;
                    mode_next = MODE_AUTO_EXIT;
                end
                else
                begin
                    lamps = LAMP_AUTO;
                end
            end
            MODE_AUTO_EXIT:
            begin
                lamps = LAMP_DRIVE;
                if (c_up)
                begin
                    cmd_valid = 1'b1;
                    cmd       = CMD_MOVE;
                    mode_next = MODE_DRIVE;
                end
            end
            default:
            begin
                // Drive, and the unused code that behaves as drive
                if (!z_up)
                begin
                    lamps     = LAMP_AIM;
                    mode_next = MODE_AIM;
                end
                else if (!c_up)
                begin
                    lamps     = LAMP_DRIVE;
                    mode_next = MODE_TO_AUTO;
                end
                else
                begin
                    cmd_valid = 1'b1;
                    cmd       = dir_cmd(CMD_MOVE, jx, jy);
                    lamps     = LAMP_DRIVE;
                    mode_next = MODE_DRIVE;
                end
            end
        endcase
    end

    // Pack the result transaction
    always_comb
    begin
        out_data_next = {{PadW{1'b0}}, lamps, cmd, c_up, z_up,
                         az, ay, ax, jy, jx};
        out_user_next = cmd_valid;
    end

    // Control state: advance only on an accepted report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CAL;
            centre_x_reg  <= '0;
            centre_y_reg  <= '0;
            leave_aim_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                centre_x_reg  <= centre_x_next;
                centre_y_reg  <= centre_y_next;
                leave_aim_reg <= leave_aim_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                // Drop the result once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next accepted report
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

FILE: rtl/core/jmce_checker.sv
// ----------------------------------------------------------------------------
// jmce_checker
// Port-level checks on the joystick mode command encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module jmce_checker
    import jmce_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OutDataW-1:0] m_tdata,
    input wire logic                m_tuser
);

    logic [ByteW-1:0] cmd_f;
    logic [LampW-1:0] lamp_f;

    assign cmd_f  = m_tdata[CmdLo +: ByteW];
    assign lamp_f = m_tdata[LampLo +: LampW];

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

    // A result transaction without a command carries a zero command byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> cmd_f == CMD_NONE)
    else $error("command byte set without command_valid");

    // Auto lamp only ever shows alongside the auto command
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && lamp_f == LAMP_AUTO |-> m_tuser && cmd_f == CMD_AUTO)
    else $error("auto lamp without auto command");

    // Shot armed: aim and shoot lamps, nothing sent
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && lamp_f == (LAMP_AIM | LAMP_SHOOT) |-> !m_tuser)
    else $error("command sent while shot is held");

    // Input accepted into a full, stalled result register would lose data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

endmodule

bind joystick_mode_command_encoder jmce_checker u_jmce_checker (.*);

`default_nettype wire

FILE: verif/joystick_mode_command_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joystick_mode_command_encoder_tb
// Streams raw controller reports into the encoder and checks every decoded
// result against a cycle-free model of the decode and mode machine. Reports
// arrive in bursts with gaps, the result side stalls on its own pattern, and
// the run passes through every mode, including the held-button waits.
// ----------------------------------------------------------------------------

module joystick_mode_command_encoder_tb;

    import jmce_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 300;

    // Mode encoding as the block steps through it
    typedef enum logic [ModeW-1:0] {
        MODE_CALIBRATE,
        MODE_DRIVE,
        MODE_AIM,
        MODE_SHOOT_HOLD,
        MODE_TO_AUTO_HOLD,
        MODE_AUTO,
        MODE_AUTO_EXIT_HOLD
    } mode_e;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_style_e;

    typedef struct {
        stick_t            stick_x;
        stick_t            stick_y;
        logic [AccelW-1:0] accel_x;
        logic [AccelW-1:0] accel_y;
        logic [AccelW-1:0] accel_z;
        logic              z_up;
        logic              c_up;
        logic              cmd_valid;
        logic [ByteW-1:0]  cmd;
        logic [LampW-1:0]  lamps;
    } decoded_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;

    // Reports waiting to be sent; the head is the one on the bus
    logic [InDataW-1:0] pending_reports [$];
    // Predicted results, oldest first
    decoded_report_t    expected_cmds [$];

    // Model state
    mode_e              mode_r = MODE_CALIBRATE;
    logic [ByteW-1:0]   centre_x_r = '0;
    logic [ByteW-1:0]   centre_y_r = '0;
    logic               leave_aim_r = 1'b0;

    // Centre that the stimulus chose for the calibration report
    logic [ByteW-1:0]   cal_x;
    logic [ByteW-1:0]   cal_y;

    int                 mismatch_cnt = 0;
    int                 cycle_cnt = 0;
    int                 burst_left = 1;
    int                 gap_left = 0;
    int                 hold_req = 0;
    int                 hold_ack = 0;
    int                 hold_left = 0;
    int                 style_left = 0;
    rx_style_e          rx_style = RX_ALWAYS;
    logic               rx_long_hold = 1'b0;

    joystick_mode_command_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // OR the direction bits for a relative stick position onto a command base
    function automatic logic [ByteW-1:0] steer(input logic [ByteW-1:0] base,
                                               input int x, input int y);
        steer = base | ((y > 0) ? DIR_UP   : CMD_NONE)
                     | ((y < 0) ? DIR_DOWN : CMD_NONE)
                     | ((x < 0) ? DIR_LEFT : CMD_NONE)
                     | ((x > 0) ? DIR_RIGHT : CMD_NONE);
    endfunction

    // Decode one report and advance the mode machine
    function automatic decoded_report_t predict_command(input logic [InDataW-1:0] raw);
        logic [ByteW-1:0] d [6];
        decoded_report_t  r;
        int               jx;
        int               jy;
        for (int i = 0; i < 6; i++)
            d[i] = (raw[i*ByteW +: ByteW] ^ KEY_BYTE) + KEY_BYTE;

        r.z_up      = d[5][0];
        r.c_up      = d[5][1];
        r.accel_x   = {d[2], d[5][2], d[5][3]};
        r.accel_y   = {d[3], d[5][4], d[5][5]};
        r.accel_z   = {d[4], d[5][6], d[5][7]};
        r.cmd_valid = 1'b0;
        r.cmd       = CMD_NONE;
        r.lamps     = LAMP_NONE;

        // The first report only latches the centre, so its stick reads zero
        if (mode_r == MODE_CALIBRATE)
        begin
            centre_x_r = d[0];
            centre_y_r = d[1];
        end
        jx = int'(d[0]) - int'(centre_x_r);
        jy = int'(d[1]) - int'(centre_y_r);
        r.stick_x = jx[StickW-1:0];
        r.stick_y = jy[StickW-1:0];

        case (mode_r)
            MODE_CALIBRATE:
                mode_r = MODE_DRIVE;
            MODE_AIM:
                if (!r.c_up)
                begin
                    // Fire pressed: remember whether to fall back to drive
                    r.lamps     = LAMP_AIM | LAMP_SHOOT;
                    leave_aim_r = r.z_up;
                    mode_r      = MODE_SHOOT_HOLD;
                end
                else
                begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = steer(CMD_AIM, jx, jy);
                    if (r.z_up)
                    begin
                        r.lamps = LAMP_DRIVE;
                        mode_r  = MODE_DRIVE;
                    end
                    else
                        r.lamps = LAMP_AIM;
                end
            MODE_SHOOT_HOLD:
                if (!r.c_up)
                    r.lamps = LAMP_AIM | LAMP_SHOOT;
                else
                begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = CMD_SHOOT;
                    if (leave_aim_r)
                    begin
                        r.lamps = LAMP_DRIVE;
                        mode_r  = MODE_DRIVE;
                    end
                    else
                    begin
                        r.lamps = LAMP_AIM;
                        mode_r  = MODE_AIM;
                    end
                end
            MODE_TO_AUTO_HOLD:
            begin
                r.lamps = LAMP_DRIVE;
                if (r.c_up)
                begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = CMD_AUTO;
                    mode_r      = MODE_AUTO;
                end
            end
            MODE_AUTO:
            begin
                // Z is ignored while in auto
                r.cmd_valid = 1'b1;
                r.cmd       = CMD_AUTO;
                if (!r.c_up)
                begin
                    r.lamps = LAMP_DRIVE;
                    mode_r  = MODE_AUTO_EXIT_HOLD;
                end
                else
                    r.lamps = LAMP_AUTO;
            end
            MODE_AUTO_EXIT_HOLD:
            begin
                r.lamps = LAMP_DRIVE;
                if (r.c_up)
                begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = CMD_MOVE;
                    mode_r      = MODE_DRIVE;
                end
            end
            default:
            begin
                // Drive, and the unused code which acts the same
                if (!r.z_up)
                begin
                    r.lamps = LAMP_AIM;
                    mode_r  = MODE_AIM;
                end
                else if (!r.c_up)
                begin
                    r.lamps = LAMP_DRIVE;
                    mode_r  = MODE_TO_AUTO_HOLD;
                end
                else
                begin
                    r.cmd_valid = 1'b1;
                    r.cmd       = steer(CMD_MOVE, jx, jy);
                    r.lamps     = LAMP_DRIVE;
                    mode_r      = MODE_DRIVE;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Inverse of the byte decode: the raw byte that decodes to d
    function automatic logic [ByteW-1:0] scramble(input logic [ByteW-1:0] d);
        logic [ByteW-1:0] t;
        t = d - KEY_BYTE;
        return t ^ KEY_BYTE;
    endfunction

    // Decoded button byte: accelerometer low bits on top, C and Z below
    function automatic logic [ByteW-1:0] button_byte(input logic [5:0] accel_lo,
                                                     input logic z_up, input logic c_up);
        return {accel_lo, c_up, z_up};
    endfunction

    // Stick byte near the centre, at a rail, or anywhere
    function automatic logic [ByteW-1:0] pick_stick(input logic [ByteW-1:0] centre);
        case ($urandom_range(0, 5))
            0:       return centre;
            1:       return centre + 8'd1;
            2:       return centre - 8'd1;
            3:       return 8'h00;
            4:       return 8'hFF;
            default: return ByteW'($urandom_range(0, 255));
        endcase
    endfunction

    // Queue one report given in decoded form
    task automatic queue_decoded(input logic [ByteW-1:0] d0, input logic [ByteW-1:0] d1,
                                 input logic [ByteW-1:0] d2, input logic [ByteW-1:0] d3,
                                 input logic [ByteW-1:0] d4, input logic [ByteW-1:0] d5);
        pending_reports.push_back({scramble(d5), scramble(d4), scramble(d3),
                                   scramble(d2), scramble(d1), scramble(d0)});
    endtask

    // Queue a run of reports holding one button pattern, or a noise report
    task automatic queue_random_run();
        logic [63:0] noise;
        logic        z_up;
        logic        c_up;
        int          reps;
        int          pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            noise = {$urandom, $urandom};
            pending_reports.push_back(noise[InDataW-1:0]);
        end
        else
        begin
            // Weight toward releases so every hold also gets left again
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: {z_up, c_up} = 2'b11;
                5, 6:          {z_up, c_up} = 2'b01;
                7, 8:          {z_up, c_up} = 2'b10;
                default:       {z_up, c_up} = 2'b00;
            endcase
            reps = $urandom_range(1, 4);
            repeat (reps)
                queue_decoded(pick_stick(cal_x), pick_stick(cal_y),
                              ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
                              ByteW'($urandom_range(0, 255)),
                              button_byte(6'($urandom_range(0, 63)), z_up, c_up));
        end
    endtask

    // Hold the sender until every queued report has produced its result
    task automatic drain_results();
        while (pending_reports.size() != 0 || expected_cmds.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the head of the report queue in bursts with random gaps.
    // Never drop tvalid before the transaction completes; during a long
    // receiver hold-off keep offering so the block backs up into its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_cmds.push_back(predict_command(pending_reports.pop_front()));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // Hold the current transaction while it is refused
            if (!(s_tvalid && !s_tready))
            begin
                if (pending_reports.size() != 0 && (gap_left == 0 || rx_long_hold))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_reports[0];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: pick a new stall pattern whenever the current one runs out, and
    // hold off for a long stretch whenever the stimulus asks for one.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_long_hold <= 1'b0;
        end
        else
        begin
            if (hold_ack != hold_req)
            begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD;
            end
            if (style_left == 0)
            begin
                style_left = $urandom_range(16, 128);
                rx_style   = rx_style_e'($urandom_range(0, 3));
            end
            else
                style_left--;

            if (hold_left > 0)
            begin
                hold_left--;
                m_tready     <= 1'b0;
                rx_long_hold <= 1'b1;
            end
            else
            begin
                rx_long_hold <= 1'b0;
                case (rx_style)
                    RX_ALWAYS: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        decoded_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("result transaction with no report pending: tdata %h", m_tdata);
                mismatch_cnt++;
            end
            else
            begin
                want = expected_cmds.pop_front();
                check_field("stick_x", int'(want.stick_x),
                            int'(stick_t'(m_tdata[StickXLo +: StickW])));
                check_field("stick_y", int'(want.stick_y),
                            int'(stick_t'(m_tdata[StickYLo +: StickW])));
                check_field("accel_x", int'(want.accel_x),
                            int'(m_tdata[AccelXLo +: AccelW]));
                check_field("accel_y", int'(want.accel_y),
                            int'(m_tdata[AccelYLo +: AccelW]));
                check_field("accel_z", int'(want.accel_z),
                            int'(m_tdata[AccelZLo +: AccelW]));
                check_field("button_z_up", int'(want.z_up), int'(m_tdata[BtnZLo]));
                check_field("button_c_up", int'(want.c_up), int'(m_tdata[BtnCLo]));
                check_field("command_valid", int'(want.cmd_valid), int'(m_tuser));
                check_field("command_byte", int'(want.cmd),
                            int'(m_tdata[CmdLo +: ByteW]));
                check_field("lamps", int'(want.lamps), int'(m_tdata[LampLo +: LampW]));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // Pick a centre: a rail, mid scale or anywhere
        case ($urandom_range(0, 3))
            0:       cal_x = 8'h00;
            1:       cal_x = 8'hFF;
            2:       cal_x = 8'h80;
            default: cal_x = ByteW'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
            0:       cal_y = 8'h00;
            1:       cal_y = 8'hFF;
            2:       cal_y = 8'h80;
            default: cal_y = ByteW'($urandom_range(0, 255));
        endcase

        // Directed walk through every mode. The first report calibrates.
        queue_decoded(cal_x, cal_y, 8'h00, 8'h00, 8'h00, button_byte(6'h00, 1'b1, 1'b1));
        // Drive: stick centred, then at both rail corners
        queue_decoded(cal_x, cal_y, 8'hFF, 8'h00, 8'hFF, button_byte(6'h3F, 1'b1, 1'b1));
        queue_decoded(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, button_byte(6'h2A, 1'b1, 1'b1));
        queue_decoded(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, button_byte(6'h15, 1'b1, 1'b1));
        // Z pressed enters aim; aim with Z held stays, release returns to drive
        queue_decoded(cal_x, cal_y, 8'h12, 8'h34, 8'h56, button_byte(6'h00, 1'b0, 1'b1));
        queue_decoded(cal_x + 8'd1, cal_y - 8'd1, 8'h9A, 8'hBC, 8'hDE,
                      button_byte(6'h3F, 1'b0, 1'b1));
        queue_decoded(cal_x - 8'd1, cal_y + 8'd1, 8'h01, 8'h02, 8'h03,
                      button_byte(6'h11, 1'b1, 1'b1));
        // Both pressed in drive: Z wins, go to aim
        queue_decoded(cal_x, cal_y, 8'h40, 8'h50, 8'h60, button_byte(6'h22, 1'b0, 1'b0));
        // Fire with Z held: shoot hold, hold again, release back to aim
        queue_decoded(8'h00, 8'h00, 8'h70, 8'h80, 8'h90, button_byte(6'h0C, 1'b0, 1'b0));
        queue_decoded(8'hFF, 8'hFF, 8'hA0, 8'hB0, 8'hC0, button_byte(6'h30, 1'b0, 1'b0));
        queue_decoded(cal_x, cal_y, 8'hD0, 8'hE0, 8'hF0, button_byte(6'h03, 1'b1, 1'b1));
        // Fire with Z up: shot returns to drive
        queue_decoded(cal_x, cal_y, 8'h0F, 8'hF0, 8'h5A, button_byte(6'h1E, 1'b1, 1'b0));
        queue_decoded(cal_x, cal_y, 8'hA5, 8'h3C, 8'hC3, button_byte(6'h21, 1'b0, 1'b1));
        // C pressed in drive: wait for release, then auto
        queue_decoded(cal_x, cal_y, 8'h11, 8'h22, 8'h33, button_byte(6'h05, 1'b1, 1'b0));
        queue_decoded(8'h00, 8'hFF, 8'h44, 8'h55, 8'h66, button_byte(6'h0A, 1'b1, 1'b0));
        queue_decoded(cal_x, cal_y, 8'h77, 8'h88, 8'h99, button_byte(6'h14, 1'b1, 1'b1));
        // Auto ignores Z; C pressed leads to the exit wait
        queue_decoded(cal_x, cal_y, 8'hAA, 8'hBB, 8'hCC, button_byte(6'h28, 1'b0, 1'b1));
        queue_decoded(cal_x, cal_y, 8'hDD, 8'hEE, 8'hFF, button_byte(6'h3F, 1'b1, 1'b0));
        queue_decoded(cal_x, cal_y, 8'h00, 8'h11, 8'h22, button_byte(6'h00, 1'b0, 1'b0));
        queue_decoded(cal_x, cal_y, 8'h33, 8'h44, 8'h55, button_byte(6'h2D, 1'b1, 1'b1));
        // Raw rail reports
        pending_reports.push_back({InDataW{1'b0}});
        pending_reports.push_back({InDataW{1'b1}});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Pause the sender until the directed results are all back
        drain_results();

        // Random part one, with a long receiver hold-off while the sender
        // keeps offering, so the result register fills and tready drops
        while (pending_reports.size() < 420)
            queue_random_run();
        @(negedge clk);
        hold_req++;
        drain_results();

        // Random part two
        while (pending_reports.size() < 880)
            queue_random_run();
        drain_results();

        // Let anything stray surface before the verdict
        repeat (8) @(posedge clk);
        if (expected_cmds.size() != 0)
            $error("%0d results never arrived", expected_cmds.size());
        if (mismatch_cnt == 0 && expected_cmds.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
